[sv/replication_ack_quorum_tracker_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the replication ack quorum tracker
// Shared concurrent assertion forms, clocked, with reset disable.
// ----------------------------------------------------------------------------
`ifndef REPLICATION_ACK_QUORUM_TRACKER_MACROS_SVH
`define REPLICATION_ACK_QUORUM_TRACKER_MACROS_SVH

// same-cycle implication
`define RQT_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("rqt assertion failed");

// next-cycle implication
`define RQT_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("rqt assertion failed");

`endif

[sv/rqt_pkg.sv]
// ----------------------------------------------------------------------------
// rqt_pkg
// Types and constants shared by the ack quorum tracker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rqt_pkg;

    localparam int MAX_SLOTS_DEF = 8;
    localparam int ID_W          = 31;
    localparam int POS_W         = 64;
    localparam int QS_W          = 4;
    localparam int OUTCOME_W     = 2;

    localparam logic [QS_W-1:0] QS_RESET = QS_W'(1);

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_STALE  = 2'd0,
        OUT_UPDATE = 2'd1,
        OUT_STORE  = 2'd2,
        OUT_QUORUM = 2'd3
    } outcome_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN1,
        ST_RESOLVE,
        ST_SCAN2,
        ST_FINAL
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic rd_en;
        logic eval1;
        logic eval2;
        logic resolve;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic full;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

[sv/rqt_if.sv]
// ----------------------------------------------------------------------------
// rqt channel interfaces
// Valid/ready channels for ack input and quorum result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface rqt_ack_if;
    logic                       valid;
    logic                       ready;
    logic [rqt_pkg::ID_W-1:0]   replica_id;
    logic [rqt_pkg::POS_W-1:0]  ack_pos;

    modport source (output valid, output replica_id, output ack_pos, input ready);
    modport sink   (input valid, input replica_id, input ack_pos, output ready);
endinterface

interface rqt_res_if;
    logic                          valid;
    logic                          ready;
    logic [rqt_pkg::OUTCOME_W-1:0] outcome;
    logic [rqt_pkg::ID_W-1:0]      quorum_replica;
    logic [rqt_pkg::POS_W-1:0]     quorum_pos;

    modport source (output valid, output outcome, output quorum_replica,
                    output quorum_pos, input ready);
    modport sink   (input valid, input outcome, input quorum_replica,
                    input quorum_pos, output ready);
endinterface

`default_nettype wire

[sv/rqt_ram.sv]
// ----------------------------------------------------------------------------
// rqt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rqt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[sv/rqt_ctrl.sv]
// ----------------------------------------------------------------------------
// rqt_ctrl
// Sequencer: slot scan passes, resolve and quorum clear steps.
// ----------------------------------------------------------------------------
`default_nettype none

module rqt_ctrl #(
    parameter int CNT_W = 4,
    parameter int IDX_W = 3
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [CNT_W-1:0]    num_slots,
    input  wire rqt_pkg::dp_status_t status,
    output rqt_pkg::ctrl_cmd_t       cmd,
    output logic      [IDX_W-1:0]    rd_idx
);

    rqt_pkg::ctrl_state_t state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 eval_reg, eval_next;
    logic                 rd_more;
    logic                 scan_done;

    assign rd_more   = cnt_reg < num_slots;
    assign scan_done = !rd_more && !eval_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rqt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rqt_pkg::ST_SCAN1;
                end
            end
            rqt_pkg::ST_SCAN1:
            begin
                if (scan_done)
                begin
                    state_next = rqt_pkg::ST_RESOLVE;
                end
            end
            rqt_pkg::ST_RESOLVE:
            begin
                if (status.full)
                begin
                    state_next = rqt_pkg::ST_SCAN2;
                end
                else if (status.out_free)
                begin
                    state_next = rqt_pkg::ST_IDLE;
                end
            end
            rqt_pkg::ST_SCAN2:
            begin
                if (scan_done)
                begin
                    state_next = rqt_pkg::ST_FINAL;
                end
            end
            rqt_pkg::ST_FINAL:
            begin
                if (status.out_free)
                begin
                    state_next = rqt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rqt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        rd_idx    = cnt_reg[IDX_W-1:0];
        cnt_next  = cnt_reg;
        eval_next = 1'b0;
        case (state_reg)
            rqt_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                cnt_next    = '0;
            end
            rqt_pkg::ST_SCAN1,
            rqt_pkg::ST_SCAN2:
            begin
                cmd.rd_en = rd_more;
                cmd.eval1 = eval_reg && (state_reg == rqt_pkg::ST_SCAN1);
                cmd.eval2 = eval_reg && (state_reg == rqt_pkg::ST_SCAN2);
                eval_next = rd_more;
                if (rd_more)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            rqt_pkg::ST_RESOLVE:
            begin
                cmd.resolve = status.full || status.out_free;
                cnt_next    = '0;
            end
            rqt_pkg::ST_FINAL:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rqt_pkg::ST_IDLE;
            cnt_reg   <= '0;
            eval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            eval_reg  <= eval_next;
        end
    end

endmodule

`default_nettype wire

[sv/rqt_datapath.sv]
// ----------------------------------------------------------------------------
// rqt_datapath
// Slot tables, scan trackers, quorum point and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "replication_ack_quorum_tracker_macros.svh"

module rqt_datapath #(
    parameter int MAX_SLOTS = 8,
    parameter int IDX_W     = 3,
    parameter int CNT_W     = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [rqt_pkg::QS_W-1:0]      cfg_wdata,
    input  wire logic [rqt_pkg::ID_W-1:0]      in_replica_id,
    input  wire logic [rqt_pkg::POS_W-1:0]     in_ack_pos,
    input  wire rqt_pkg::ctrl_cmd_t            cmd,
    input  wire logic [IDX_W-1:0]              rd_idx,
    output rqt_pkg::dp_status_t                status,
    output logic      [CNT_W-1:0]              num_slots,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [rqt_pkg::OUTCOME_W-1:0] out_outcome,
    output logic      [rqt_pkg::ID_W-1:0]      out_replica,
    output logic      [rqt_pkg::POS_W-1:0]     out_pos
);

    localparam int ID_W  = rqt_pkg::ID_W;
    localparam int POS_W = rqt_pkg::POS_W;
    localparam int QS_W  = rqt_pkg::QS_W;

    logic [QS_W-1:0]      qsize_reg;
    logic [MAX_SLOTS-1:0] valid_reg, valid_next;
    logic [ID_W-1:0]      id_reg, lq_rep_reg, min_rep_reg, out_rep_reg;
    logic [POS_W-1:0]     pos_reg, lq_pos_reg, min_pos_reg, match_pos_reg, out_pos_reg;
    logic                 match_reg, free_reg, min_reg;
    logic [IDX_W-1:0]     match_idx_reg, free_idx_reg, eval_idx_reg;
    rqt_pkg::outcome_t    out_outcome_reg;
    logic                 out_valid_reg;

    logic [ID_W-1:0]      rd_rep;
    logic [POS_W-1:0]     rd_pos;
    logic [7:0]           n_raw;
    logic                 stale, full, out_free, load;
    logic                 slot_occ, hit_match, hit_min, hit_clear;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_idx;
    logic [ID_W-1:0]      q_rep;
    logic [POS_W-1:0]     q_pos;

    rqt_ram #(.WIDTH(ID_W), .DEPTH(MAX_SLOTS), .AW(IDX_W)) u_rep_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_idx),
        .wdata (id_reg),
        .re    (cmd.rd_en),
        .raddr (rd_idx),
        .rdata (rd_rep)
    );

    rqt_ram #(.WIDTH(POS_W), .DEPTH(MAX_SLOTS), .AW(IDX_W)) u_pos_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_idx),
        .wdata (pos_reg),
        .re    (cmd.rd_en),
        .raddr (rd_idx),
        .rdata (rd_pos)
    );

    // active slots: quorum_size - 1, zero for size 0, capped at MAX_SLOTS
    always_comb
    begin
        n_raw = (qsize_reg == '0) ? 8'd0 : (8'(qsize_reg) - 8'd1);
        if (n_raw > 8'(MAX_SLOTS))
        begin
            num_slots = CNT_W'(MAX_SLOTS);
        end
        else
        begin
            num_slots = CNT_W'(n_raw);
        end
    end

    assign stale           = (id_reg == '0) || (pos_reg < lq_pos_reg);
    assign full            = !stale && !match_reg && !free_reg;
    assign out_free        = !out_valid_reg || out_ready;
    assign status.full     = full;
    assign status.out_free = out_free;
    assign load            = (cmd.resolve && !full) || cmd.finish;

    assign slot_occ  = valid_reg[eval_idx_reg];
    assign hit_match = cmd.eval1 && slot_occ && (rd_rep == id_reg) && !match_reg;
    assign hit_min   = cmd.eval1 && slot_occ && (rd_pos < min_pos_reg);
    assign hit_clear = cmd.eval2 && (rd_pos == lq_pos_reg);

    assign q_rep = min_reg ? min_rep_reg : id_reg;
    assign q_pos = min_reg ? min_pos_reg : pos_reg;

    always_comb
    begin
        wr_en  = 1'b0;
        wr_idx = free_idx_reg;
        if (cmd.resolve && !stale)
        begin
            if (match_reg)
            begin
                wr_en  = match_pos_reg < pos_reg;
                wr_idx = match_idx_reg;
            end
            else if (free_reg)
            begin
                wr_en = 1'b1;
            end
        end
        if (cmd.finish)
        begin
            wr_en = free_reg && (pos_reg > lq_pos_reg);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (hit_clear)
        begin
            valid_next[eval_idx_reg] = 1'b0;
        end
        if (wr_en)
        begin
            valid_next[wr_idx] = 1'b1;
        end
        if (cfg_we)
        begin
            valid_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qsize_reg     <= rqt_pkg::QS_RESET;
            valid_reg     <= '0;
            lq_rep_reg    <= '0;
            lq_pos_reg    <= '0;
            match_reg     <= 1'b0;
            free_reg      <= 1'b0;
            min_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg_we)
            begin
                qsize_reg <= cfg_wdata;
            end
            if (cmd.capture)
            begin
                match_reg <= 1'b0;
                free_reg  <= 1'b0;
                min_reg   <= 1'b0;
            end
            if (cmd.eval1 && !slot_occ)
            begin
                free_reg <= 1'b1;
            end
            if (hit_match)
            begin
                match_reg <= 1'b1;
            end
            if (hit_min)
            begin
                min_reg <= 1'b1;
            end
            if (cmd.resolve)
            begin
                free_reg <= 1'b0;
            end
            if (hit_clear)
            begin
                free_reg <= 1'b1;
            end
            if (cmd.resolve && full)
            begin
                lq_rep_reg <= q_rep;
                lq_pos_reg <= q_pos;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            id_reg      <= in_replica_id;
            pos_reg     <= in_ack_pos;
            min_pos_reg <= in_ack_pos;
        end
        if (cmd.rd_en)
        begin
            eval_idx_reg <= rd_idx;
        end
        if ((cmd.eval1 && !slot_occ) || hit_clear)
        begin
            free_idx_reg <= eval_idx_reg;
        end
        if (hit_match)
        begin
            match_idx_reg <= eval_idx_reg;
            match_pos_reg <= rd_pos;
        end
        if (hit_min)
        begin
            min_pos_reg <= rd_pos;
            min_rep_reg <= rd_rep;
        end
        if (cmd.finish)
        begin
            out_outcome_reg <= rqt_pkg::OUT_QUORUM;
            out_rep_reg     <= lq_rep_reg;
            out_pos_reg     <= lq_pos_reg;
        end
        else if (cmd.resolve && !full)
        begin
            if (stale)
            begin
                out_outcome_reg <= rqt_pkg::OUT_STALE;
            end
            else if (match_reg)
            begin
                out_outcome_reg <= rqt_pkg::OUT_UPDATE;
            end
            else
            begin
                out_outcome_reg <= rqt_pkg::OUT_STORE;
            end
            out_rep_reg <= '0;
            out_pos_reg <= '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_outcome = out_outcome_reg;
    assign out_replica = out_rep_reg;
    assign out_pos     = out_pos_reg;

    `RQT_ASSERT_IMPL(a_load_when_free, clk, rst_n, load, out_free)
    `RQT_ASSERT_IMPL(a_quorum_monotonic, clk, rst_n, 1'b1, lq_pos_reg >= $past(lq_pos_reg))
    `RQT_ASSERT_NEXT(a_finish_quorum, clk, rst_n, cmd.finish, out_valid_reg && (out_outcome_reg == rqt_pkg::OUT_QUORUM))

endmodule

`default_nettype wire

[sv/replication_ack_quorum_tracker.sv]
// ----------------------------------------------------------------------------
// replication_ack_quorum_tracker
// Tracks replica acks in quorum_size-1 slots and reports quorum points.
// ----------------------------------------------------------------------------
// Usage:
//   ack: valid/ready sink, one transaction per replica ack (id, position).
//   res: valid/ready source, exactly one result transaction per ack.
//   cfg_we/cfg_wdata: quorum_size write; empties all slots, keeps the last
//   quorum point. Write only while no ack is in flight.
// Sequence, with n active slots (0..MAX_SLOTS):
//   A scan pass reads the n slots of the slot RAMs, one read per cycle.
//   Stale, update and free-slot acks: one scan pass, then the result is
//   registered; the next ack is accepted once the tracker is idle again.
//   Quorum acks add a clearing pass before the result is registered.
// Reset: quorum_size = 1, all slots empty, last quorum point zero.
// Stall: the result register holds one transaction; the next ack is taken
//   and scanned meanwhile, and its result waits until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module replication_ack_quorum_tracker #(
    parameter int MAX_SLOTS = rqt_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [rqt_pkg::QS_W-1:0] cfg_wdata,
    rqt_ack_if.sink                       ack,
    rqt_res_if.source                     res
);

    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);

    rqt_pkg::ctrl_cmd_t  cmd;
    rqt_pkg::dp_status_t status;
    logic [IDX_W-1:0]    rd_idx;
    logic [CNT_W-1:0]    num_slots;

    rqt_ctrl #(.CNT_W(CNT_W), .IDX_W(IDX_W)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ack.valid),
        .in_ready  (ack.ready),
        .num_slots (num_slots),
        .status    (status),
        .cmd       (cmd),
        .rd_idx    (rd_idx)
    );

    rqt_datapath #(.MAX_SLOTS(MAX_SLOTS), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_replica_id (ack.replica_id),
        .in_ack_pos    (ack.ack_pos),
        .cmd           (cmd),
        .rd_idx        (rd_idx),
        .status        (status),
        .num_slots     (num_slots),
        .out_valid     (res.valid),
        .out_ready     (res.ready),
        .out_outcome   (res.outcome),
        .out_replica   (res.quorum_replica),
        .out_pos       (res.quorum_pos)
    );

endmodule

`default_nettype wire
